@@ design/ale_pkg.sv @@
// Shared definitions for the array list engine: operation, status and cell
// command codes, the default list capacity and the cell command struct.
// No dependencies.
package ale_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  // Operation codes carried on in_func.
  localparam logic [2:0] OP_APPEND       = 3'd0;
  localparam logic [2:0] OP_INSERT       = 3'd1;
  localparam logic [2:0] OP_REMOVE_AT    = 3'd2;
  localparam logic [2:0] OP_READ         = 3'd3;
  localparam logic [2:0] OP_FIND         = 3'd4;
  localparam logic [2:0] OP_REMOVE_VALUE = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_POS   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Commands broadcast to every cell of the chain.
  localparam logic [1:0] CMD_HOLD       = 2'd0;
  localparam logic [1:0] CMD_INSERT     = 2'd1;
  localparam logic [1:0] CMD_DROP_POS   = 2'd2;
  localparam logic [1:0] CMD_DROP_MATCH = 2'd3;

  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] word;
  } cell_cmd_t;

endpackage

@@ design/ale_cell.sv @@
// One storage cell of the list chain: holds one word, flags its own position
// and match at capture, and on command shifts from its neighbors or takes the new word.
// Depends on ale_pkg.
module ale_cell import ale_pkg::*; #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 7,
  parameter int unsigned PW    = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cap_en,
  input  logic [31:0]      key,
  input  logic [PW-1:0]    pos,
  input  logic [CNT_W-1:0] count,
  input  cell_cmd_t        cmd,
  input  logic [31:0]      left_word,
  input  logic [31:0]      right_word,
  input  logic             seen_in,
  output logic [31:0]      word_r,
  output logic             seen_out,
  output logic             first,
  output logic             sel
);

  logic [31:0] word_nxt;
  logic        match_r, match_nxt;
  logic        ge_r, ge_nxt;
  logic        eq_r, eq_nxt;
  logic        live;

  assign live = CNT_W'(INDEX) < count;

  // Capture-time flags: does this live entry equal the key, and where does
  // this cell sit relative to the requested position.
  always_comb begin
    match_nxt = match_r;
    ge_nxt    = ge_r;
    eq_nxt    = eq_r;
    if (cap_en) begin
      match_nxt = live && (word_r == key);
      ge_nxt    = PW'(INDEX) >= pos;
      eq_nxt    = PW'(INDEX) == pos;
    end
  end

  // The seen flag ripples up the chain, so every cell at or above the first
  // match knows it must close the gap.
  assign seen_out = seen_in | match_r;
  assign first    = match_r & ~seen_in;
  assign sel      = eq_r;

  always_comb begin
    word_nxt = word_r;
    case (cmd.code)
      CMD_INSERT: begin
        if (eq_r) begin
          word_nxt = cmd.word;
        end else if (ge_r) begin
          word_nxt = left_word;
        end
      end
      CMD_DROP_POS: begin
        if (ge_r) begin
          word_nxt = right_word;
        end
      end
      CMD_DROP_MATCH: begin
        if (seen_out) begin
          word_nxt = right_word;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
      ge_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      match_r <= match_nxt;
      ge_r    <= ge_nxt;
      eq_r    <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

@@ design/ale_gather.sv @@
// Collects results from the cell chain: encodes the one-hot first match into
// an index and selects the word of the addressed cell.
// Depends on ale_pkg.
module ale_gather import ale_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned IDX_W    = 6
) (
  input  logic [CAPACITY-1:0] first,
  input  logic [CAPACITY-1:0] sel,
  input  logic [31:0]         words [CAPACITY],
  output logic [IDX_W-1:0]    hit_idx,
  output logic [31:0]         rd_word
);

  always_comb begin
    hit_idx = '0;
    rd_word = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (sel[i]) begin
        rd_word = rd_word | words[i];
      end
    end
  end

endmodule

@@ design/array_list_engine_top.sv @@
// Top level of the array list engine: FSM, entry count, result register and
// the chain of ale_cell storage cells. Depends on ale_pkg, ale_cell, ale_gather.
//
// The engine keeps an ordered list of up to CAPACITY signed 32-bit words in a
// row of cells, one word per cell, with an entry count. Each input transfer
// requests one operation (append, insert at a position, remove at a position,
// read, find a value, remove the first entry holding a value) and yields
// exactly one result transfer carrying status, data, found index and the
// count after the operation. An item is accepted, then executed: in the accept
// cycle every cell compares its word with the key and its own index with the
// position; in the execute cycle the first-match ripple along the chain and
// the index encoder settle, the result is registered, and all cells shift
// toward or away from the chosen place at once. Execute waits only while an
// earlier result still sits unaccepted in the output register, so a result
// can wait while the next item is being taken in. in_stall is high during
// the execute cycle. Cells that lie above the entry count hold undefined
// words; they never reach a result.
module array_list_engine_top import ale_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_value,
  input  logic [6:0]         in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic [5:0]         out_found_index,
  output logic [6:0]         out_count
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned PW    = (CNT_W > 7) ? CNT_W : 7;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [2:0]       func_r;
  logic [31:0]      value_r;
  logic [PW-1:0]    pos_r;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       status_r;
  logic [31:0]      data_r;
  logic [5:0]       found_r;
  logic [6:0]       ocount_r;

  logic             accept;
  logic             fire;
  logic [PW-1:0]    cap_pos;
  cell_cmd_t        cmd;

  logic [31:0]         words   [CAPACITY];
  logic [31:0]         left_w  [CAPACITY];
  logic [31:0]         right_w [CAPACITY];
  logic [CAPACITY:0]   seen;
  logic [CAPACITY-1:0] first_v;
  logic [CAPACITY-1:0] sel_v;
  logic [IDX_W-1:0]    hit_idx;
  logic [31:0]         rd_word;

  logic             any_match;
  logic             full;
  logic [PW-1:0]    cnt_ext;
  logic [1:0]       res_status;
  logic [31:0]      res_data;
  logic [5:0]       res_found;
  logic [CNT_W-1:0] res_count;
  logic [1:0]       act;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign fire     = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // Append is an insert at the current end of the list.
  assign cap_pos = (in_func == OP_APPEND) ? PW'(count_r) : PW'(in_position);

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_lo
      assign left_w[g] = words[g];
    end else begin : g_lo
      assign left_w[g] = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign right_w[g] = words[g];
    end else begin : g_hi
      assign right_w[g] = words[g+1];
    end

    ale_cell #(
      .INDEX (g),
      .CNT_W (CNT_W),
      .PW    (PW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cap_en     (accept),
      .key        (in_value),
      .pos        (cap_pos),
      .count      (count_r),
      .cmd        (cmd),
      .left_word  (left_w[g]),
      .right_word (right_w[g]),
      .seen_in    (seen[g]),
      .word_r     (words[g]),
      .seen_out   (seen[g+1]),
      .first      (first_v[g]),
      .sel        (sel_v[g])
    );
  end

  ale_gather #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_gather (
    .first   (first_v),
    .sel     (sel_v),
    .words   (words),
    .hit_idx (hit_idx),
    .rd_word (rd_word)
  );

  assign any_match = seen[CAPACITY];
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign cnt_ext   = PW'(count_r);

  // Result and chain command for the captured item.
  always_comb begin
    res_status = ST_OK;
    res_data   = '0;
    res_found  = '0;
    res_count  = count_r;
    act        = CMD_HOLD;
    unique case (func_r)
      OP_APPEND: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          act       = CMD_INSERT;
          res_count = count_r + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        // The position check wins over the full check.
        if (pos_r > cnt_ext) begin
          res_status = ST_BAD_POS;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          act       = CMD_INSERT;
          res_count = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE_AT: begin
        if (pos_r >= cnt_ext) begin
          res_status = ST_BAD_POS;
        end else begin
          act       = CMD_DROP_POS;
          res_count = count_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pos_r >= cnt_ext) begin
          res_status = ST_BAD_POS;
        end else begin
          res_data = rd_word;
        end
      end
      OP_FIND: begin
        if (any_match) begin
          res_found = 6'(hit_idx);
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_REMOVE_VALUE: begin
        if (any_match) begin
          res_found = 6'(hit_idx);
          act       = CMD_DROP_MATCH;
          res_count = count_r - CNT_W'(1);
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign cmd.code = fire ? act : CMD_HOLD;
  assign cmd.word = value_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign count_nxt = fire ? res_count : count_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      value_r <= in_value;
      pos_r   <= cap_pos;
    end
    if (fire) begin
      status_r <= res_status;
      data_r   <= res_data;
      found_r  <= res_found;
      ocount_r <= 7'(res_count);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_data        = data_r;
  assign out_found_index = found_r;
  assign out_count       = ocount_r;

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_first_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first_v))
    else $error("more than one first match in the chain");

  a_sel_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel_v))
    else $error("more than one cell selected for read");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> count_r == $past(count_r))
    else $error("entry count changed without a completed operation");

  a_drop_match : assert property (@(posedge clk) disable iff (!rst_n)
    (fire && func_r == OP_REMOVE_VALUE && any_match)
      |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("remove by value did not shrink the list");
`endif

endmodule
